/* hdl/bfa_pkg.sv */
package bfa_pkg;

    localparam int MAP_FRAMES = 4096;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = (MAP_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;
    localparam int POS_W      = 14;

    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_ONE = 3'd0,
        OP_ALLOC_RUN = 3'd1,
        OP_FREE_RUN  = 3'd2,
        OP_ADD_REGION = 3'd3,
        OP_MARK_USED = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_MEM  = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

endpackage

/* hdl/bfa_ram.sv */
module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/bitmap_frame_allocator.sv */
// Bitmap frame allocator: one used/free bit per frame, kept in a word RAM.
// Input channel i_valid/o_stall carries one request word: operation, start frame
// and frame count. Output channel o_valid/i_stall returns one result word per
// request: allocated frame, status and free count after the operation.
// Each request walks the bitmap one word per pass through a shared sequencer:
// a pass reads a word (a registered RAM read), works one bit of it per cycle
// and writes it back; an operation touches up to NUM_WORDS words, and an
// alloc run may walk the whole map and then mark the run it found. An
// unknown operation skips the walk and goes straight to its result.
// One request is in work at a time; o_stall is high from acceptance until the
// result is loaded into the output register. A stalled result holds there,
// and a finished request waits for it to be taken.
// After reset the RAM is swept to all ones, one word a cycle, during which
// no request is accepted. Hint, limit and free count reset to zero.
module bitmap_frame_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [11:0] i_start_frame,
    input  logic [12:0] i_frame_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_result_frame,
    output logic [1:0]  o_status,
    output logic [12:0] o_free_count
);
    localparam int W  = bfa_pkg::WORD_BITS;
    localparam int AW = bfa_pkg::WADDR_W;
    localparam int BW = bfa_pkg::BIT_W;
    localparam int PW = bfa_pkg::POS_W;
    localparam int CW = bfa_pkg::COUNT_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_READ  = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_BIT   = 9'b000100000,
        S_WRITE = 9'b001000000,
        S_FIX0  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [2:0]    r_op, n_op;
    logic [PW-1:0] r_lo, n_lo;      // current frame position
    logic [PW-1:0] r_hi, n_hi;      // exclusive end of walk
    logic [PW-1:0] r_first, n_first;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_need, n_need;
    logic          r_mark, n_mark;  // alloc run: second walk marks
    logic          r_found, n_found;
    logic [CW-1:0] r_hint, n_hint;
    logic [CW-1:0] r_limit, n_limit;
    logic [CW-1:0] r_free, n_free;
    logic [W-1:0]  r_word, n_word;
    logic          r_dirty, n_dirty;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_ovalid, n_ovalid;
    logic [11:0]   r_res, n_res;
    logic [1:0]    r_stat, n_stat;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [W-1:0]  wdata, rdata;

    bfa_ram #(.WIDTH(W), .DEPTH(bfa_pkg::NUM_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [BW-1:0] bitpos;
    logic          bit_used;
    logic [PW-1:0] start_ext, end_ext;
    logic          word_last;

    assign bitpos    = r_lo[BW-1:0];
    assign bit_used  = r_word[bitpos];
    assign start_ext = PW'(i_start_frame);
    assign end_ext   = PW'(i_start_frame) + PW'(i_frame_count);
    assign word_last = (bitpos == BW'(W - 1)) || (r_lo + PW'(1) >= r_hi);

    always_comb begin
        n_state = r_state; n_op = r_op; n_lo = r_lo; n_hi = r_hi;
        n_first = r_first; n_run = r_run; n_need = r_need; n_mark = r_mark;
        n_found = r_found; n_hint = r_hint; n_limit = r_limit; n_free = r_free;
        n_word = r_word; n_dirty = r_dirty; n_clr = r_clr;
        n_ovalid = r_ovalid; n_res = r_res; n_stat = r_stat;
        we = 1'b0; waddr = r_lo[BW +: AW]; wdata = r_word;
        raddr = r_lo[BW +: AW];

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1; waddr = r_clr; wdata = bfa_pkg::ALL_ONES;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(bfa_pkg::NUM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_operation; n_need = i_frame_count;
                    n_run = '0; n_first = '0; n_mark = 1'b0; n_found = 1'b0;
                    n_res = '0; n_stat = bfa_pkg::ST_OK; n_dirty = 1'b0;
                    n_state = S_SETUP;
                    unique case (i_operation)
                        bfa_pkg::OP_ALLOC_ONE: begin
                            n_lo = PW'(r_hint); n_hi = PW'(r_limit);
                            n_stat = bfa_pkg::ST_NO_MEM;
                        end
                        bfa_pkg::OP_ALLOC_RUN: begin
                            n_lo = '0; n_hi = PW'(bfa_pkg::MAP_FRAMES);
                            n_stat = bfa_pkg::ST_NO_MEM;
                        end
                        bfa_pkg::OP_FREE_RUN, bfa_pkg::OP_MARK_USED: begin
                            n_lo = start_ext; n_hi = end_ext;
                        end
                        bfa_pkg::OP_ADD_REGION: begin
                            n_lo = start_ext; n_hi = end_ext;
                            if (start_ext >= PW'(bfa_pkg::MAP_FRAMES)) begin
                                n_stat = bfa_pkg::ST_IGNORED;
                                n_state = S_DONE;
                            end else begin
                                if (end_ext > PW'(bfa_pkg::MAP_FRAMES))
                                    n_hi = PW'(bfa_pkg::MAP_FRAMES);
                                n_hint = CW'(start_ext);
                                n_limit = (end_ext > PW'(bfa_pkg::MAP_FRAMES)) ?
                                    CW'(bfa_pkg::MAP_FRAMES) : CW'(end_ext);
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                // clip walk at the map end
                if (r_hi > PW'(bfa_pkg::MAP_FRAMES)) n_hi = PW'(bfa_pkg::MAP_FRAMES);
                n_state = S_READ;
            end
            S_READ: begin
                if (r_lo >= r_hi) begin
                    if (r_op == bfa_pkg::OP_ALLOC_RUN && !r_mark && r_need == '0
                        && r_found) begin
                        n_stat = bfa_pkg::ST_OK; n_res = r_first[11:0];
                        n_state = S_DONE;
                    end else if (r_op == bfa_pkg::OP_ADD_REGION) begin
                        n_lo = '0; n_hi = PW'(1); n_state = S_FIX0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_word = rdata; n_dirty = 1'b0; n_state = S_BIT;
            end
            S_BIT: begin
                n_lo = r_lo + PW'(1);
                if (word_last) n_state = S_WRITE;
                priority case (1'b1)
                    r_op == bfa_pkg::OP_ALLOC_ONE: begin
                        if (!bit_used) begin
                            n_word[bitpos] = 1'b1; n_dirty = 1'b1;
                            n_free = r_free - CW'(1);
                            n_hint = CW'(r_lo + PW'(1));
                            n_res = r_lo[11:0]; n_stat = bfa_pkg::ST_OK;
                            n_hi = r_lo + PW'(1);
                            n_state = S_WRITE;
                        end
                    end
                    r_op == bfa_pkg::OP_ALLOC_RUN && r_mark: begin
                        if (!bit_used) begin
                            n_word[bitpos] = 1'b1; n_dirty = 1'b1;
                            n_free = r_free - CW'(1);
                        end
                    end
                    r_op == bfa_pkg::OP_ALLOC_RUN: begin
                        if (!bit_used) begin
                            if (r_run == '0) n_first = r_lo;
                            n_run = r_run + CW'(1);
                            if (r_run + CW'(1) >= r_need) begin
                                n_found = 1'b1;
                                n_hi = r_lo + PW'(1);
                                n_state = S_WRITE;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end
                    r_op == bfa_pkg::OP_MARK_USED: begin
                        if (!bit_used) begin
                            n_word[bitpos] = 1'b1; n_dirty = 1'b1;
                            n_free = r_free - CW'(1);
                        end
                    end
                    default: begin // free run, add region
                        if (bit_used) begin
                            n_word[bitpos] = 1'b0; n_dirty = 1'b1;
                            n_free = r_free + CW'(1);
                        end
                    end
                endcase
            end
            S_WRITE: begin
                we = r_dirty;
                waddr = AW'((r_lo - PW'(1)) >> BW);
                n_state = S_READ;
                if (r_op == bfa_pkg::OP_ALLOC_RUN && !r_mark && r_found) begin
                    if (r_need == '0) begin
                        n_stat = bfa_pkg::ST_OK; n_res = r_first[11:0];
                        n_state = S_DONE;
                    end else begin
                        n_mark = 1'b1; n_lo = r_first;
                        n_hi = r_first + PW'(r_need);
                    end
                end else if (r_op == bfa_pkg::OP_ALLOC_RUN && r_mark
                             && r_lo >= r_hi) begin
                    n_stat = bfa_pkg::ST_OK; n_res = r_first[11:0];
                    n_state = S_DONE;
                end else if (r_op == bfa_pkg::OP_ALLOC_ONE
                             && r_stat == bfa_pkg::ST_OK) begin
                    n_state = S_DONE;
                end
            end
            S_FIX0: begin
                // force frame 0 used after a region add
                n_op = bfa_pkg::OP_MARK_USED; n_state = S_READ;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_hint <= '0; r_limit <= '0;
            r_free <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_hint <= n_hint;
            r_limit <= n_limit; r_free <= n_free; r_ovalid <= n_ovalid;
        end
        r_op <= n_op; r_lo <= n_lo; r_hi <= n_hi; r_first <= n_first;
        r_run <= n_run; r_need <= n_need; r_mark <= n_mark; r_found <= n_found;
        r_word <= n_word; r_dirty <= n_dirty; r_res <= n_res; r_stat <= n_stat;
    end

    // output register holds while stalled; r_res/r_stat change only in work
    logic [11:0] r_ores;
    logic [1:0]  r_ostat;
    logic [12:0] r_ofree;
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
            r_ores <= r_res; r_ostat <= r_stat; r_ofree <= r_free;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_result_frame = r_ores;
    assign o_status       = r_ostat;
    assign o_free_count   = r_ofree;
endmodule
